### design/dmcu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dmcu_pkg;

  // Channel limits
  localparam int NUM_CHANNELS_DEF = 2;
  localparam int CNT_W            = 2;

  // Field widths
  localparam int OP_W       = 3;
  localparam int CH_W       = 2;
  localparam int SPD_IN_W   = 8;
  localparam int DIR_IN_W   = 3;
  localparam int ERR_W      = 2;
  localparam int STAT_W     = 2;
  localparam int DIR_W      = 2;
  localparam int SPD_W      = 7;
  localparam int DUTY_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;

  // Result queue geometry
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

  // Speed limit and duty scaling: duty = speed * 32768 / 100, done as a
  // multiply by ceil(2^16 * 327.68) and a 16 bit right shift
  localparam logic [SPD_IN_W-1:0] SPEED_LIMIT_IN = 8'd100;
  localparam logic [SPD_W-1:0]    SPEED_LIMIT    = 7'd100;
  localparam logic [31:0]         DUTY_RECIP     = 32'd21474837;

  typedef enum logic [OP_W-1:0] {
    OP_SET_SPEED = 3'd0,
    OP_SET_DIR   = 3'd1,
    OP_SET_BOTH  = 3'd2,
    OP_READ      = 3'd3,
    OP_BRAKE_ALL = 3'd4
  } op_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK        = 2'd0,
    ERR_CHANNEL   = 2'd1,
    ERR_SPEED     = 2'd2,
    ERR_DIRECTION = 2'd3
  } err_t;

  typedef enum logic [STAT_W-1:0] {
    ST_INVALID = 2'd0,
    ST_IDLE    = 2'd1,
    ST_RUNNING = 2'd2
  } status_t;

  typedef enum logic [DIR_W-1:0] {
    DIR_FORWARD = 2'd0,
    DIR_REVERSE = 2'd1,
    DIR_BRAKE   = 2'd2,
    DIR_COAST   = 2'd3
  } dir_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHANNEL_COUNT = 3'd0,
    CFG_MIN_SPEED_A   = 3'd1,
    CFG_MAX_SPEED_A   = 3'd2,
    CFG_INVERT_A      = 3'd3,
    CFG_MIN_SPEED_B   = 3'd4,
    CFG_MAX_SPEED_B   = 3'd5,
    CFG_INVERT_B      = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [ERR_W-1:0]  error;
    logic [CH_W-1:0]   result_channel;
    logic [STAT_W-1:0] status;
    logic [DIR_W-1:0]  cur_direction;
    logic [SPD_W-1:0]  cur_speed;
    logic [DUTY_W-1:0] duty;
    logic              dir_pin;
    logic              last;
  } result_t;

  // Convert a speed percent (up to 127) to PWM duty, 32768 is full
  function automatic logic [DUTY_W-1:0] speed_to_duty(input logic [SPD_W-1:0] s);
    logic [31:0] prod;
    prod = 32'(s) * DUTY_RECIP;
    return prod[31:16];
  endfunction

endpackage

`default_nettype wire

### design/dual_motor_command_unit.sv
// Dual motor command unit.
// Input channel (in_valid / in_stall): one command per transaction, taken at
// a rising edge with in_valid high and in_stall low. A set command can update the
// stored direction, run flag, speed, duty and direction pin of its channel.
// Result channel (out_valid / out_stall): one result per command, one per
// channel in use for brake all, none for an unknown operation.
// Config channel (cfg_valid / cfg_ready): register writes by index; cfg_ready
// is always high. Write only while no results are pending.
// A command's result is written into the result queue at the edge that takes it.
// Throughput: one command per cycle while in_stall is low; the state update and
// duty multiply sit between the input ports and a four-entry result queue.
// in_stall rises when fewer than two queue entries are free, so a brake-all
// result pair always fits. With the receiver taking a result every cycle only
// brake-all commands over two channels close together stall the input.
// A stalled receiver holds the head result stable and backs the queue up.
// Reset (rst_n low, synchronous): all channels coast with zero speed, duty
// and pin, configuration returns to two channels, min 0, max 100, no invert,
// and the queue empties.
`timescale 1ns / 1ps
`default_nettype none

module dual_motor_command_unit #(
  parameter int NUM_CHANNELS = dmcu_pkg::NUM_CHANNELS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // command channel
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [dmcu_pkg::OP_W-1:0]       in_operation,
  input  wire logic [dmcu_pkg::CH_W-1:0]       in_channel,
  input  wire logic [dmcu_pkg::SPD_IN_W-1:0]   in_speed,
  input  wire logic [dmcu_pkg::DIR_IN_W-1:0]   in_direction,
  // result channel
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [dmcu_pkg::ERR_W-1:0]           out_error,
  output logic [dmcu_pkg::CH_W-1:0]            out_result_channel,
  output logic [dmcu_pkg::STAT_W-1:0]          out_status,
  output logic [dmcu_pkg::DIR_W-1:0]           out_cur_direction,
  output logic [dmcu_pkg::SPD_W-1:0]           out_cur_speed,
  output logic [dmcu_pkg::DUTY_W-1:0]          out_duty,
  output logic                                 out_dir_pin,
  output logic                                 out_last,
  // configuration channel
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [dmcu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [dmcu_pkg::CFG_DATA_W-1:0] cfg_data
);

  import dmcu_pkg::*;

  // Configuration registers
  logic [CNT_W-1:0] chan_cnt_r;
  logic [SPD_W-1:0] min_a_r, max_a_r, min_b_r, max_b_r;
  logic             inv_a_r, inv_b_r;

  // Per-channel state
  logic [DIR_W-1:0]  dir_r   [NUM_CHANNELS];
  logic              run_r   [NUM_CHANNELS];
  logic [SPD_W-1:0]  speed_r [NUM_CHANNELS];
  logic [DUTY_W-1:0] duty_r  [NUM_CHANNELS];
  logic              pin_r   [NUM_CHANNELS];

  logic [DIR_W-1:0]  dir_nxt   [NUM_CHANNELS];
  logic              run_nxt   [NUM_CHANNELS];
  logic [SPD_W-1:0]  speed_nxt [NUM_CHANNELS];
  logic [DUTY_W-1:0] duty_nxt  [NUM_CHANNELS];
  logic              pin_nxt   [NUM_CHANNELS];

  // Result queue
  result_t           fifo_r [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r, wr_ptr_nxt, rd_ptr_nxt;
  logic [FCNT_W-1:0] count_r, count_nxt;

  // Command decode
  logic              in_acc, pop;
  logic [CNT_W-1:0]  n_ch;
  logic              ch_ok, dir_ok, sp_ok, is_dir_op, apply_dir, want_speed, apply_speed;
  logic              single_op;
  logic [DIR_W-1:0]  d2;
  logic [SPD_W-1:0]  s7, min_sel, max_sel, s_lim, t0, t_duty;
  logic              inv_sel;
  logic [DIR_W-1:0]  cur_dir, dir1, dir2;
  logic              cur_run, run1, run2;
  logic [SPD_W-1:0]  cur_spd, spd1, spd2;
  logic [DUTY_W-1:0] cur_duty, duty1, duty2, duty_new;
  logic              cur_pin, pin1, pin_calc;
  err_t              err;
  result_t           res0, res1;
  logic [1:0]        push;

  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && !in_stall;
  assign pop       = out_valid && !out_stall;
  assign in_stall  = count_r > FCNT_W'(FIFO_DEPTH - 2);
  assign out_valid = count_r != '0;

  // Drive the head of the queue
  always_comb begin
    out_error          = fifo_r[rd_ptr_r].error;
    out_result_channel = fifo_r[rd_ptr_r].result_channel;
    out_status         = fifo_r[rd_ptr_r].status;
    out_cur_direction  = fifo_r[rd_ptr_r].cur_direction;
    out_cur_speed      = fifo_r[rd_ptr_r].cur_speed;
    out_duty           = fifo_r[rd_ptr_r].duty;
    out_dir_pin        = fifo_r[rd_ptr_r].dir_pin;
    out_last           = fifo_r[rd_ptr_r].last;
  end

  // Decode the command and compute the addressed channel's new state
  always_comb begin
    n_ch = (chan_cnt_r < CNT_W'(NUM_CHANNELS)) ? chan_cnt_r : CNT_W'(NUM_CHANNELS);
    ch_ok = in_channel < n_ch;

    // select the addressed channel's state and settings
    cur_dir  = DIR_COAST;
    cur_run  = 1'b0;
    cur_spd  = '0;
    cur_duty = '0;
    cur_pin  = 1'b0;
    for (int g = 0; g < NUM_CHANNELS; g++) begin
      if (in_channel == CH_W'(g)) begin
        cur_dir  = dir_r[g];
        cur_run  = run_r[g];
        cur_spd  = speed_r[g];
        cur_duty = duty_r[g];
        cur_pin  = pin_r[g];
      end
    end
    min_sel = in_channel[0] ? min_b_r : min_a_r;
    max_sel = in_channel[0] ? max_b_r : max_a_r;
    inv_sel = in_channel[0] ? inv_b_r : inv_a_r;

    dir_ok    = !in_direction[DIR_IN_W-1];
    d2        = in_direction[DIR_W-1:0];
    sp_ok     = in_speed <= SPEED_LIMIT_IN;
    s7        = in_speed[SPD_W-1:0];
    is_dir_op = (in_operation == OP_SET_DIR) || (in_operation == OP_SET_BOTH);
    apply_dir = is_dir_op && dir_ok;
    single_op = in_operation <= OP_READ;

    // direction step
    unique case (d2)
      DIR_FORWARD: pin_calc = !inv_sel;
      DIR_REVERSE: pin_calc = inv_sel;
      DIR_BRAKE:   pin_calc = 1'b1;
      default:     pin_calc = 1'b0;
    endcase
    dir1  = apply_dir ? d2 : cur_dir;
    pin1  = apply_dir ? pin_calc : cur_pin;
    run1  = cur_run;
    spd1  = cur_spd;
    duty1 = cur_duty;
    if (apply_dir) begin
      if (d2[1]) begin
        run1  = 1'b0;
        spd1  = '0;
        duty1 = '0;
      end else begin
        run1 = cur_spd != '0;
      end
    end

    // speed step: clamp to max, raise to min, then duty from a value capped at 100 and raised to min again
    want_speed = (in_operation == OP_SET_SPEED) ||
                 ((in_operation == OP_SET_BOTH) && dir_ok && !d2[1]);
    apply_speed = want_speed && sp_ok;
    if (s7 > max_sel) begin
      s_lim = max_sel;
    end else if ((s7 != '0) && (s7 < min_sel)) begin
      s_lim = min_sel;
    end else begin
      s_lim = s7;
    end
    t0       = (s_lim > SPEED_LIMIT) ? SPEED_LIMIT : s_lim;
    t_duty   = ((t0 != '0) && (t0 < min_sel)) ? min_sel : t0;
    duty_new = speed_to_duty(t_duty);

    dir2  = dir1;
    spd2  = apply_speed ? s_lim : spd1;
    duty2 = apply_speed ? duty_new : duty1;
    run2  = apply_speed ? ((s_lim != '0) && !dir1[1]) : run1;

    // error code
    unique case (in_operation)
      OP_SET_SPEED: err = sp_ok ? ERR_OK : ERR_SPEED;
      OP_SET_DIR:   err = dir_ok ? ERR_OK : ERR_DIRECTION;
      OP_SET_BOTH: begin
        if (!dir_ok) begin
          err = ERR_DIRECTION;
        end else if (want_speed && !sp_ok) begin
          err = ERR_SPEED;
        end else begin
          err = ERR_OK;
        end
      end
      default:      err = ERR_OK;
    endcase

    // build results
    res0 = '0;
    res1 = '0;
    push = 2'd0;
    if (in_operation == OP_BRAKE_ALL) begin
      res0.error          = ERR_OK;
      res0.result_channel = CH_W'(0);
      res0.status         = ST_IDLE;
      res0.cur_direction  = DIR_BRAKE;
      res0.dir_pin        = 1'b1;
      res0.last           = n_ch == CNT_W'(1);
      res1                = res0;
      res1.result_channel = CH_W'(1);
      res1.last           = 1'b1;
      push                = n_ch;
    end else if (single_op) begin
      res0.result_channel = in_channel;
      res0.last           = 1'b1;
      push                = 2'd1;
      if (!ch_ok) begin
        res0.error = ERR_CHANNEL;
      end else begin
        res0.error         = err;
        res0.status        = run2 ? ST_RUNNING : ST_IDLE;
        res0.cur_direction = dir2;
        res0.cur_speed     = spd2;
        res0.duty          = duty2;
        res0.dir_pin       = pin1;
      end
    end
  end

  // Next per-channel state
  always_comb begin
    for (int g = 0; g < NUM_CHANNELS; g++) begin
      dir_nxt[g]   = dir_r[g];
      run_nxt[g]   = run_r[g];
      speed_nxt[g] = speed_r[g];
      duty_nxt[g]  = duty_r[g];
      pin_nxt[g]   = pin_r[g];
      if (in_acc) begin
        if ((in_operation == OP_BRAKE_ALL) && (CNT_W'(g) < n_ch)) begin
          dir_nxt[g]   = DIR_BRAKE;
          run_nxt[g]   = 1'b0;
          speed_nxt[g] = '0;
          duty_nxt[g]  = '0;
          pin_nxt[g]   = 1'b1;
        end else if (single_op && ch_ok && (in_channel == CH_W'(g))) begin
          dir_nxt[g]   = dir2;
          run_nxt[g]   = run2;
          speed_nxt[g] = spd2;
          duty_nxt[g]  = duty2;
          pin_nxt[g]   = pin1;
        end
      end
    end
  end

  // Queue pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (in_acc) begin
      wr_ptr_nxt = wr_ptr_r + PTR_W'(push);
      count_nxt  = count_nxt + FCNT_W'(push);
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + PTR_W'(1);
      count_nxt  = count_nxt - FCNT_W'(1);
    end
  end

  // Hold configuration, channel state and queue control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_cnt_r <= CNT_W'(2);
      min_a_r    <= '0;
      max_a_r    <= SPEED_LIMIT;
      inv_a_r    <= 1'b0;
      min_b_r    <= '0;
      max_b_r    <= SPEED_LIMIT;
      inv_b_r    <= 1'b0;
      for (int g = 0; g < NUM_CHANNELS; g++) begin
        dir_r[g]   <= DIR_COAST;
        run_r[g]   <= 1'b0;
        speed_r[g] <= '0;
        duty_r[g]  <= '0;
        pin_r[g]   <= 1'b0;
      end
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_CHANNEL_COUNT: chan_cnt_r <= cfg_data[CNT_W-1:0];
          CFG_MIN_SPEED_A:   min_a_r    <= cfg_data[SPD_W-1:0];
          CFG_MAX_SPEED_A:   max_a_r    <= cfg_data[SPD_W-1:0];
          CFG_INVERT_A:      inv_a_r    <= cfg_data[0];
          CFG_MIN_SPEED_B:   min_b_r    <= cfg_data[SPD_W-1:0];
          CFG_MAX_SPEED_B:   max_b_r    <= cfg_data[SPD_W-1:0];
          CFG_INVERT_B:      inv_b_r    <= cfg_data[0];
          default: ;
        endcase
      end
      for (int g = 0; g < NUM_CHANNELS; g++) begin
        dir_r[g]   <= dir_nxt[g];
        run_r[g]   <= run_nxt[g];
        speed_r[g] <= speed_nxt[g];
        duty_r[g]  <= duty_nxt[g];
        pin_r[g]   <= pin_nxt[g];
      end
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Write result entries for an accepted transaction
  always_ff @(posedge clk) begin
    if (in_acc && (push != 2'd0)) begin
      fifo_r[wr_ptr_r] <= res0;
    end
    if (in_acc && (push == 2'd2)) begin
      fifo_r[wr_ptr_r + PTR_W'(1)] <= res1;
    end
  end

endmodule

`default_nettype wire

### verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import dmcu_pkg::*;

  localparam int NUM_CH          = NUM_CHANNELS_DEF;
  localparam int RESET_CYCLES    = 9;
  localparam int DRAIN_CYCLES    = 8;
  localparam int HOLDOFF_CYCLES  = 120;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int MAX_SHOWN       = 10;
  localparam int ROUND_ITEMS     = 120;
  localparam int PERCENT_FULL    = 100;
  localparam int DUTY_FULL       = 32768;

  // Codes outside the defined command and direction sets
  localparam logic [OP_W-1:0]     OP_FIRST_UNUSED = 3'd5;
  localparam logic [OP_W-1:0]     OP_LAST_UNUSED  = 3'd7;
  localparam logic [DIR_IN_W-1:0] DIR_FIRST_BAD   = 3'd4;
  localparam logic [DIR_IN_W-1:0] DIR_LAST_BAD    = 3'd7;

  typedef struct {
    dir_t              dir;
    logic              run;
    logic [SPD_W-1:0]  spd;
    logic [DUTY_W-1:0] duty;
    logic              pin;
  } motor_state_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [OP_W-1:0]       in_operation = '0;
  logic [CH_W-1:0]       in_channel = '0;
  logic [SPD_IN_W-1:0]   in_speed = '0;
  logic [DIR_IN_W-1:0]   in_direction = '0;

  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [ERR_W-1:0]      out_error;
  logic [CH_W-1:0]       out_result_channel;
  logic [STAT_W-1:0]     out_status;
  logic [DIR_W-1:0]      out_cur_direction;
  logic [SPD_W-1:0]      out_cur_speed;
  logic [DUTY_W-1:0]     out_duty;
  logic                  out_dir_pin;
  logic                  out_last;

  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Mirror of the motor state and the limit registers
  motor_state_t     motor [NUM_CH];
  logic [CNT_W-1:0] lim_count;
  logic [SPD_W-1:0] lim_min [NUM_CH];
  logic [SPD_W-1:0] lim_max [NUM_CH];
  logic             lim_inv [NUM_CH];

  result_t reports_due [$];

  int tx_idle_pct = 31;
  int rx_idle_pct = 47;
  int holdoff_req = 0;
  int holdoff_ack = 0;
  int holdoff_left = 0;

  int unsigned cycle_count = 0;
  int unsigned input_stalls = 0;
  int unsigned fail_count = 0;
  int unsigned reports_seen = 0;
  int unsigned commands_sent = 0;
  int unsigned brake_runs = 0;
  int unsigned backpressure_stalls = 0;

  dual_motor_command_unit u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_operation       (in_operation),
    .in_channel         (in_channel),
    .in_speed           (in_speed),
    .in_direction       (in_direction),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_error          (out_error),
    .out_result_channel (out_result_channel),
    .out_status         (out_status),
    .out_cur_direction  (out_cur_direction),
    .out_cur_speed      (out_cur_speed),
    .out_duty           (out_duty),
    .out_dir_pin        (out_dir_pin),
    .out_last           (out_last),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Motor state mirror
  // ---------------------------------------------------------------------------

  function automatic void reset_model();
    lim_count = CNT_W'(NUM_CH);
    for (int i = 0; i < NUM_CH; i++) begin
      lim_min[i] = '0;
      lim_max[i] = SPEED_LIMIT;
      lim_inv[i] = 1'b0;
      motor[i].dir = DIR_COAST;
      motor[i].run = 1'b0;
      motor[i].spd = '0;
      motor[i].duty = '0;
      motor[i].pin = 1'b0;
    end
  endfunction

  function automatic int unsigned live_channels();
    return (lim_count < NUM_CH) ? lim_count : NUM_CH;
  endfunction

  // Duty uses the stored speed capped at full scale, then raised to the minimum
  function automatic logic [DUTY_W-1:0] duty_of(int unsigned ch, int unsigned s);
    int unsigned v;
    v = s;
    if (v > PERCENT_FULL) v = PERCENT_FULL;
    if (v != 0 && v < lim_min[ch]) v = lim_min[ch];
    return DUTY_W'((v * DUTY_FULL) / PERCENT_FULL);
  endfunction

  function automatic err_t set_speed(int unsigned ch, logic [SPD_IN_W-1:0] sp);
    int unsigned v;
    if (sp > SPEED_LIMIT_IN) return ERR_SPEED;
    v = sp;
    if (v > lim_max[ch]) v = lim_max[ch];
    else if (v != 0 && v < lim_min[ch]) v = lim_min[ch];
    motor[ch].duty = duty_of(ch, v);
    motor[ch].spd = SPD_W'(v);
    motor[ch].run = (v != 0) &&
                    (motor[ch].dir == DIR_FORWARD || motor[ch].dir == DIR_REVERSE);
    return ERR_OK;
  endfunction

  function automatic err_t set_direction(int unsigned ch, logic [DIR_IN_W-1:0] d);
    dir_t nd;
    if (d >= DIR_FIRST_BAD) return ERR_DIRECTION;
    nd = dir_t'(d[DIR_W-1:0]);
    // brake and coast ignore the invert setting
    case (nd)
      DIR_FORWARD: motor[ch].pin = !lim_inv[ch];
      DIR_REVERSE: motor[ch].pin = lim_inv[ch];
      DIR_BRAKE:   motor[ch].pin = 1'b1;
      default:     motor[ch].pin = 1'b0;
    endcase
    motor[ch].dir = nd;
    if (nd == DIR_BRAKE || nd == DIR_COAST) begin
      motor[ch].run = 1'b0;
      motor[ch].spd = '0;
      motor[ch].duty = '0;
    end else begin
      motor[ch].run = (motor[ch].spd != 0);
    end
    return ERR_OK;
  endfunction

  function automatic result_t report_of(err_t err, int unsigned ch, bit show, bit last_one);
    result_t r;
    r = '0;
    r.error = err;
    r.result_channel = CH_W'(ch);
    r.last = last_one;
    if (show) begin
      r.status = motor[ch].run ? ST_RUNNING : ST_IDLE;
      r.cur_direction = motor[ch].dir;
      r.cur_speed = motor[ch].spd;
      r.duty = motor[ch].duty;
      r.dir_pin = motor[ch].pin;
    end
    return r;
  endfunction

  // Update the mirror for one accepted command and queue the reports it owes
  function automatic void run_command(logic [OP_W-1:0] op, logic [CH_W-1:0] ch,
                                      logic [SPD_IN_W-1:0] sp, logic [DIR_IN_W-1:0] d);
    int unsigned n;
    err_t err;
    n = live_channels();
    if (op == OP_BRAKE_ALL) begin
      brake_runs++;
      for (int unsigned i = 0; i < n; i++) begin
        void'(set_direction(i, DIR_BRAKE));
        reports_due.push_back(report_of(ERR_OK, i, 1'b1, i + 1 == n));
      end
    end else if (op <= OP_READ) begin
      if (ch >= n) begin
        reports_due.push_back(report_of(ERR_CHANNEL, ch, 1'b0, 1'b1));
      end else begin
        case (op)
          OP_SET_SPEED: err = set_speed(ch, sp);
          OP_SET_DIR:   err = set_direction(ch, d);
          OP_SET_BOTH: begin
            // direction first; speed only follows forward or reverse
            err = set_direction(ch, d);
            if (err == ERR_OK && d < DIR_BRAKE) err = set_speed(ch, sp);
          end
          default:      err = ERR_OK;
        endcase
        reports_due.push_back(report_of(err, ch, 1'b1, 1'b1));
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Channel drivers
  // ---------------------------------------------------------------------------

  // Offer one command; valid is decided before looking at stall and held until taken
  task automatic send_cmd(input logic [OP_W-1:0] op, input logic [CH_W-1:0] ch,
                          input logic [SPD_IN_W-1:0] sp, input logic [DIR_IN_W-1:0] d);
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_channel <= ch;
    in_speed <= sp;
    in_direction <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    commands_sent++;
    run_command(op, ch, sp, d);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input int unsigned value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_CHANNEL_COUNT: lim_count = CNT_W'(value);
      CFG_MIN_SPEED_A:   lim_min[0] = SPD_W'(value);
      CFG_MAX_SPEED_A:   lim_max[0] = SPD_W'(value);
      CFG_INVERT_A:      lim_inv[0] = value[0];
      CFG_MIN_SPEED_B:   lim_min[1] = SPD_W'(value);
      CFG_MAX_SPEED_B:   lim_max[1] = SPD_W'(value);
      CFG_INVERT_B:      lim_inv[1] = value[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_limits(input int ch, input int unsigned mn, input int unsigned mx,
                              input bit inv);
    write_reg(ch ? CFG_MIN_SPEED_B : CFG_MIN_SPEED_A, mn);
    write_reg(ch ? CFG_MAX_SPEED_B : CFG_MAX_SPEED_A, mx);
    write_reg(ch ? CFG_INVERT_B : CFG_INVERT_A, inv);
  endtask

  // Drop valid, wait for every owed report, then let the pipeline settle
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Result receiver: random stalls, or a long hold-off when one is requested
  always @(negedge clk) begin
    if (holdoff_req != holdoff_ack) begin
      holdoff_ack = holdoff_req;
      holdoff_left = HOLDOFF_CYCLES;
    end
    if (holdoff_left > 0) begin
      holdoff_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  // Compare each taken report with the oldest one owed
  always @(posedge clk) begin
    result_t seen;
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      seen = {out_error, out_result_channel, out_status, out_cur_direction,
              out_cur_speed, out_duty, out_dir_pin, out_last};
      reports_seen++;
      if (reports_due.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_SHOWN)
          $display("unexpected report: err=%0d ch=%0d st=%0d dir=%0d spd=%0d duty=%0d",
                   seen.error, seen.result_channel, seen.status, seen.cur_direction,
                   seen.cur_speed, seen.duty);
      end else begin
        want = reports_due.pop_front();
        if (seen.error !== want.error || seen.result_channel !== want.result_channel ||
            seen.status !== want.status || seen.cur_direction !== want.cur_direction ||
            seen.cur_speed !== want.cur_speed || seen.duty !== want.duty ||
            seen.dir_pin !== want.dir_pin || seen.last !== want.last) begin
          fail_count++;
          if (fail_count <= MAX_SHOWN) begin
            $display("report %0d want: err=%0d ch=%0d st=%0d dir=%0d spd=%0d duty=%0d pin=%0b last=%0b",
                     reports_seen, want.error, want.result_channel, want.status,
                     want.cur_direction, want.cur_speed, want.duty, want.dir_pin, want.last);
            $display("report %0d got:  err=%0d ch=%0d st=%0d dir=%0d spd=%0d duty=%0d pin=%0b last=%0b",
                     reports_seen, seen.error, seen.result_channel, seen.status,
                     seen.cur_direction, seen.cur_speed, seen.duty, seen.dir_pin, seen.last);
          end
        end
      end
    end
  end

  // Watchdog and stall bookkeeping
  always @(posedge clk) begin
    cycle_count++;
    if (in_valid && in_stall) input_stalls++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d reports still owed",
               cycle_count, reports_due.size());
      $display("dual_motor_command_unit test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_after_reset();
    send_cmd(OP_READ, 0, 0, DIR_FORWARD);
    send_cmd(OP_READ, 1, 0, DIR_FORWARD);
    send_cmd(OP_READ, 3, 0, DIR_FORWARD);
    send_cmd(OP_SET_SPEED, 2, 50, DIR_FORWARD);
  endtask

  task automatic test_single_commands();
    send_cmd(OP_SET_DIR, 0, 0, DIR_FORWARD);
    send_cmd(OP_SET_SPEED, 0, SPEED_LIMIT_IN, DIR_FORWARD);
    send_cmd(OP_SET_SPEED, 0, 0, DIR_FORWARD);
    send_cmd(OP_SET_SPEED, 0, SPEED_LIMIT_IN + 1, DIR_FORWARD);
    send_cmd(OP_SET_SPEED, 0, 255, DIR_FORWARD);
    send_cmd(OP_SET_DIR, 0, 0, DIR_REVERSE);
    send_cmd(OP_SET_DIR, 0, 0, DIR_LAST_BAD);
  endtask

  task automatic test_set_both();
    send_cmd(OP_SET_BOTH, 1, 50, DIR_FORWARD);
    // speed is ignored for brake and coast, even when out of range
    send_cmd(OP_SET_BOTH, 1, 255, DIR_BRAKE);
    // bad speed after a good direction keeps the new direction
    send_cmd(OP_SET_BOTH, 1, 200, DIR_REVERSE);
    send_cmd(OP_SET_BOTH, 1, 30, DIR_FIRST_BAD);
    send_cmd(OP_SET_BOTH, 1, 0, DIR_COAST);
  endtask

  task automatic test_brake_all();
    send_cmd(OP_SET_SPEED, 0, 75, DIR_FORWARD);
    send_cmd(OP_BRAKE_ALL, 0, 0, DIR_FORWARD);
    for (int o = OP_FIRST_UNUSED; o <= OP_LAST_UNUSED; o++)
      send_cmd(OP_W'(o), 0, 40, DIR_FORWARD);
  endtask

  task automatic test_config_extremes();
    // no channels in use: brake all is silent, every channel is bad
    wait_idle();
    write_reg(CFG_CHANNEL_COUNT, 0);
    send_cmd(OP_BRAKE_ALL, 0, 0, DIR_BRAKE);
    send_cmd(OP_READ, 0, 0, DIR_FORWARD);
    // count above the channel limit saturates to two
    wait_idle();
    write_reg(CFG_CHANNEL_COUNT, 3);
    send_cmd(OP_BRAKE_ALL, 0, 0, DIR_BRAKE);
    send_cmd(OP_READ, 2, 0, DIR_FORWARD);
    wait_idle();
    write_reg(CFG_CHANNEL_COUNT, 1);
    send_cmd(OP_BRAKE_ALL, 0, 0, DIR_BRAKE);
    send_cmd(OP_SET_SPEED, 1, 20, DIR_FORWARD);
    // minimum above maximum, inverted pins, zero maximum
    wait_idle();
    write_reg(CFG_CHANNEL_COUNT, 2);
    write_limits(0, 60, 40, 1'b1);
    write_limits(1, 100, 0, 1'b1);
    send_cmd(OP_SET_BOTH, 0, 80, DIR_FORWARD);
    send_cmd(OP_SET_SPEED, 0, 10, DIR_FORWARD);
    send_cmd(OP_SET_BOTH, 1, 30, DIR_REVERSE);
    send_cmd(OP_SET_SPEED, 1, SPEED_LIMIT_IN, DIR_FORWARD);
    wait_idle();
    write_limits(1, 100, 100, 1'b0);
    send_cmd(OP_SET_BOTH, 1, 1, DIR_FORWARD);
    wait_idle();
  endtask

  task automatic shuffle_config();
    int unsigned roll;
    int unsigned mn;
    int unsigned mx;
    roll = $urandom_range(0, 99);
    write_reg(CFG_CHANNEL_COUNT, roll < 70 ? 2 : (roll < 85 ? 1 : 3));
    for (int ch = 0; ch < NUM_CH; ch++) begin
      roll = $urandom_range(0, 99);
      if (roll < 40) begin
        mn = 0;
        mx = PERCENT_FULL;
      end else if (roll < 70) begin
        mn = $urandom_range(0, 50);
        mx = $urandom_range(50, PERCENT_FULL);
      end else if (roll < 85) begin
        mn = $urandom_range(0, PERCENT_FULL);
        mx = $urandom_range(0, PERCENT_FULL);
      end else begin
        mn = $urandom_range(0, 1) ? PERCENT_FULL : 0;
        mx = $urandom_range(0, 1) ? PERCENT_FULL : 0;
      end
      write_limits(ch, mn, mx, $urandom_range(0, 1));
    end
  endtask

  // Mostly well-formed commands on live channels, some out-of-range fields
  task automatic pick_command(output logic [OP_W-1:0] op, output logic [CH_W-1:0] ch,
                              output logic [SPD_IN_W-1:0] sp, output logic [DIR_IN_W-1:0] d);
    int unsigned roll;
    int unsigned n;
    n = live_channels();
    roll = $urandom_range(0, 99);
    if (roll < 28) op = OP_SET_SPEED;
    else if (roll < 48) op = OP_SET_DIR;
    else if (roll < 76) op = OP_SET_BOTH;
    else if (roll < 88) op = OP_READ;
    else if (roll < 95) op = OP_BRAKE_ALL;
    else op = OP_W'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
    if (n != 0 && $urandom_range(0, 9) != 0) ch = CH_W'($urandom_range(0, n - 1));
    else ch = CH_W'($urandom_range(0, 3));
    roll = $urandom_range(0, 99);
    if (roll < 8) sp = '0;
    else if (roll < 16) sp = SPEED_LIMIT_IN;
    else if (roll < 90) sp = SPD_IN_W'($urandom_range(1, PERCENT_FULL));
    else sp = SPD_IN_W'($urandom_range(PERCENT_FULL + 1, 255));
    roll = $urandom_range(0, 99);
    if (roll < 60) d = $urandom_range(0, 1) ? DIR_REVERSE : DIR_FORWARD;
    else if (roll < 85) d = $urandom_range(0, 1) ? DIR_COAST : DIR_BRAKE;
    else d = DIR_IN_W'($urandom_range(DIR_FIRST_BAD, DIR_LAST_BAD));
  endtask

  task automatic test_random_traffic(input int tx_pct, input int rx_pct);
    logic [OP_W-1:0]     op;
    logic [CH_W-1:0]     ch;
    logic [SPD_IN_W-1:0] sp;
    logic [DIR_IN_W-1:0] d;
    int                  sent;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int round = 0; round < 3; round++) begin
      wait_idle();
      shuffle_config();
      sent = 0;
      while (sent < ROUND_ITEMS) begin
        pick_command(op, ch, sp, d);
        send_cmd(op, ch, sp, d);
        // ignored operations do not count toward the round
        if (op <= OP_BRAKE_ALL) sent++;
      end
    end
    wait_idle();
  endtask

  // Receiver stops for a long stretch while commands keep coming
  task automatic test_backpressure();
    int unsigned stalls_before;
    wait_idle();
    write_reg(CFG_CHANNEL_COUNT, 2);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    stalls_before = input_stalls;
    holdoff_req++;
    for (int i = 0; i < 24; i++) begin
      if (i % 4 == 3) send_cmd(OP_BRAKE_ALL, 0, 0, DIR_BRAKE);
      else send_cmd(OP_SET_BOTH, CH_W'(i % 2), SPD_IN_W'($urandom_range(1, PERCENT_FULL)),
                    DIR_FORWARD);
    end
    wait_idle();
    backpressure_stalls = input_stalls - stalls_before;
  endtask

  initial begin
    reset_model();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_after_reset();
    test_single_commands();
    test_set_both();
    test_brake_all();
    test_config_extremes();
    test_random_traffic(31, 47);
    test_random_traffic(47, 31);
    test_random_traffic(0, 0);
    test_backpressure();
    wait_idle();

    $display("covered %0d commands and %0d reports (%0d brake-all runs) in %0d cycles",
             commands_sent, reports_seen, brake_runs, cycle_count);
    $display("channel counts 0..3, min/max/invert extremes; input stalled %0d cycles on hold-off",
             backpressure_stalls);
    if (fail_count == 0 && reports_due.size() == 0) begin
      $display("dual_motor_command_unit test passed");
    end else begin
      $display("%0d failures, %0d reports never arrived", fail_count, reports_due.size());
      $display("dual_motor_command_unit test failed");
    end
    $finish;
  end

endmodule
